>>> design/lks_pkg.sv
package lks_pkg;

	// Field widths fixed by the item formats
	localparam int DATA_W  = 32;
	localparam int KEY_W   = 6;
	localparam int KC_W    = 7;
	localparam int PADDR_W = 3;

	// Keyframe table depth, tied to the key index width
	localparam int MAX_KEYS = 64;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Register index, taken from paddr[PADDR_W-1:2]
	localparam logic REG_KEY_COUNT = 1'b0;

	// Input item
	typedef struct packed {
		logic                     command;
		logic [KEY_W-1:0]         key_index;
		logic [DATA_W-1:0]        key_span;
		logic signed [DATA_W-1:0] key_start_value;
		logic signed [DATA_W-1:0] key_end_value;
		logic [DATA_W-1:0]        time_step;
	} lks_in_t;

	// Result item
	typedef struct packed {
		logic signed [DATA_W-1:0] sample_value;
		logic [KEY_W-1:0]         active_key;
	} lks_out_t;

	// One keyframe as stored in the table
	typedef struct packed {
		logic [DATA_W-1:0] span;
		logic [DATA_W-1:0] v0;
		logic [DATA_W-1:0] v1;
	} lks_entry_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} lks_div_sts_t;

endpackage

>>> design/lks_ram.sv
module lks_ram #(
	parameter int WIDTH  = 96,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/lks_div.sv
module lks_div import lks_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] rem_init,
	input  logic [DATA_W:0]   bits_init,
	input  logic [DATA_W-1:0] divisor,
	output lks_div_sts_t      sts,
	output logic [DATA_W-1:0] quot,
	output logic [DATA_W-1:0] rem
);

	// One quotient bit per cycle; rem_init must already be below the divisor
	localparam int STEPS = DATA_W + 1;
	localparam int CNT_W = $clog2(STEPS);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W:0]   sh_q;
	logic [DATA_W-1:0] dvs_q;

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              ge;

	// Restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, sh_q[DATA_W]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			sh_q  <= bits_init;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			sh_q  <= {sh_q[DATA_W-1:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = sh_q[DATA_W-1:0];
	assign rem      = rem_q;

endmodule

>>> design/looping_keyframe_sampler_top.sv
// Load item: written to the keyframe RAM at the transfer; no result.
// Step item: one RAM read per cycle to sum the loop length over the N active keys, then
//   the key walk; a modulo on the shared 33-step divider when the time wraps the whole loop,
//   and a check of the current key first when it lies beyond the key count.
// One item in work at a time; the next is taken once the result sits in the output register.
// Reset clears control, key to 0, elapsed time to 0, key count to 1; table is unset.
module looping_keyframe_sampler_top import lks_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  lks_in_t            in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lks_out_t           out_data
);

	localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int LAP_W = DATA_W + AW + 1;
	localparam int ENT_W = $bits(lks_entry_t);
	localparam logic [KC_W-1:0] KEYS_MAX = KC_W'(MAX_KEYS);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_PRE  = 10'b0000000010,
		S_PREC = 10'b0000000100,
		S_LAP  = 10'b0000001000,
		S_MOD  = 10'b0000010000,
		S_WALK = 10'b0000100000,
		S_MUL  = 10'b0001000000,
		S_DST  = 10'b0010000000,
		S_DIV  = 10'b0100000000,
		S_FIN  = 10'b1000000000
	} state_t;

	state_t                   state_q;
	logic [KC_W-1:0]          key_count_q;
	logic [KEY_W-1:0]         cur_key_q;
	logic [DATA_W-1:0]        elapsed_q;
	logic                     rd_vld_s1;
	logic                     out_valid_q;
	lks_out_t                 out_q;

	logic [KC_W-1:0]          n_q;
	logic [LAP_W-1:0]         lap_q;
	logic [KC_W-1:0]          lap_idx_q;
	logic [KEY_W-1:0]         wk_q;
	logic [DATA_W-1:0]        span_q;
	logic signed [DATA_W-1:0] v0_q;
	logic [DATA_W-1:0]        mag_q;
	logic                     neg_q;
	logic [2*DATA_W-1:0]      prod_q;

	logic                     accept;
	logic                     cfg_we;
	logic [DATA_W:0]          sum_w;
	logic [DATA_W-1:0]        e_sat;
	logic [KC_W-1:0]          n_w;
	logic [KEY_W-1:0]         k_w;
	logic                     ram_we;
	lks_entry_t               ram_wdata;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic [ENT_W-1:0]         rd_raw;
	lks_entry_t               rd_data;
	logic                     fits;
	logic [DATA_W-1:0]        e_sub;
	logic [DATA_W:0]          diff_w;
	logic [DATA_W:0]          neg_diff;
	logic                     lap_done;
	logic                     lap_wrap;
	logic                     found;
	logic                     fin_go;
	logic [2*DATA_W:0]        dividend;
	logic                     div_start;
	logic [DATA_W-1:0]        div_rem_init;
	logic [DATA_W:0]          div_bits;
	logic [DATA_W-1:0]        div_divisor;
	lks_div_sts_t             div_sts;
	logic [DATA_W-1:0]        div_quot;
	logic [DATA_W-1:0]        div_rem;

	function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k,
			input logic [KC_W-1:0] n);
		logic [KC_W-1:0] kp;
		kp = {1'b0, k} + 1'b1;
		return (kp >= n) ? '0 : kp[KEY_W-1:0];
	endfunction

	// Configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;
	assign prdata = (paddr[PADDR_W-1:2] == REG_KEY_COUNT) ?
		{{(32 - KC_W){1'b0}}, key_count_q} : '0;

	// Item acceptance and step setup
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign sum_w    = {1'b0, elapsed_q} + {1'b0, in_data.time_step};
	assign e_sat    = sum_w[DATA_W] ? '1 : sum_w[DATA_W-1:0];
	assign k_w      = ({1'b0, cur_key_q} < KEYS_MAX) ? cur_key_q : '0;

	always_comb begin
		priority if (key_count_q == '0) begin
			n_w = KC_W'(1);
		end else if (key_count_q > KEYS_MAX) begin
			n_w = KEYS_MAX;
		end else begin
			n_w = key_count_q;
		end
	end

	// Keyframe write; a zero span is stored as one LSB
	assign ram_we          = accept && (in_data.command == CMD_LOAD)
		&& ({1'b0, in_data.key_index} < KEYS_MAX);
	assign ram_wdata.span  = (in_data.key_span == '0) ? DATA_W'(1) : in_data.key_span;
	assign ram_wdata.v0    = in_data.key_start_value;
	assign ram_wdata.v1    = in_data.key_end_value;

	// Read port address per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_PRE: begin
				rd_en   = 1'b1;
				rd_addr = cur_key_q[AW-1:0];
			end
			S_LAP: begin
				rd_en   = (lap_idx_q < n_q);
				rd_addr = lap_idx_q[AW-1:0];
			end
			S_WALK: begin
				rd_en   = 1'b1;
				rd_addr = wk_q[AW-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	lks_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_KEYS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_data.key_index[AW-1:0]),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);

	assign rd_data = rd_raw;

	// Span check against elapsed time and segment delta
	assign fits     = rd_data.span <= elapsed_q;
	assign e_sub    = elapsed_q - rd_data.span;
	assign diff_w   = {rd_data.v1[DATA_W-1], rd_data.v1} - {rd_data.v0[DATA_W-1], rd_data.v0};
	assign neg_diff = '0 - diff_w;

	assign lap_done = (state_q == S_LAP) && (lap_idx_q == n_q) && !rd_vld_s1;
	assign lap_wrap = {{(LAP_W - DATA_W){1'b0}}, elapsed_q} >= lap_q;
	assign found    = ((state_q == S_PREC) && !fits)
		|| ((state_q == S_WALK) && rd_vld_s1 && !fits);
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Divider: lap wrap (elapsed mod loop length) or rounded blend quotient
	assign dividend = {1'b0, prod_q} + {{(DATA_W + 2){1'b0}}, span_q[DATA_W-1:1]};

	always_comb begin
		if (state_q == S_DST) begin
			div_start    = 1'b1;
			div_rem_init = dividend[2*DATA_W:DATA_W+1];
			div_bits     = dividend[DATA_W:0];
			div_divisor  = span_q;
		end else begin
			div_start    = lap_done && lap_wrap;
			div_rem_init = '0;
			div_bits     = {1'b0, elapsed_q};
			div_divisor  = lap_q[DATA_W-1:0];
		end
	end

	lks_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.rem_init  (div_rem_init),
		.bits_init (div_bits),
		.divisor   (div_divisor),
		.sts       (div_sts),
		.quot      (div_quot),
		.rem       (div_rem)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= KC_W'(1);
			cur_key_q   <= '0;
			elapsed_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (paddr[PADDR_W-1:2] == REG_KEY_COUNT)) begin
				key_count_q <= pwdata[KC_W-1:0];
			end
			// Result register: loaded when a step finishes, emptied by its transfer
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept && (in_data.command == CMD_STEP)) begin
						elapsed_q <= e_sat;
						cur_key_q <= k_w;
						state_q   <= ({1'b0, k_w} >= n_w) ? S_PRE : S_LAP;
					end
				end
				S_PRE: begin
					state_q <= S_PREC;
				end
				S_PREC: begin
					if (fits) begin
						elapsed_q <= e_sub;
						cur_key_q <= '0;
						state_q   <= S_LAP;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_LAP: begin
					rd_vld_s1 <= rd_en;
					if (lap_done) begin
						state_q <= lap_wrap ? S_MOD : S_WALK;
					end
				end
				S_MOD: begin
					if (div_sts.done) begin
						elapsed_q <= div_rem;
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					if (rd_vld_s1 && !fits) begin
						rd_vld_s1 <= 1'b0;
						state_q   <= S_MUL;
					end else begin
						rd_vld_s1 <= 1'b1;
						if (rd_vld_s1) begin
							elapsed_q <= e_sub;
							cur_key_q <= next_key(cur_key_q, n_q);
						end
					end
				end
				S_MUL: begin
					state_q <= S_DST;
				end
				S_DST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the step
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_w;
		end
		if ((state_q == S_IDLE) || (state_q == S_PREC)) begin
			lap_q     <= '0;
			lap_idx_q <= '0;
		end else if (state_q == S_LAP) begin
			if (rd_en) begin
				lap_idx_q <= lap_idx_q + 1'b1;
			end
			if (rd_vld_s1) begin
				lap_q <= lap_q + {{(LAP_W - DATA_W){1'b0}}, rd_data.span};
			end
		end
		// Walk read pointer runs one read ahead of the key being checked
		if (state_q == S_WALK) begin
			wk_q <= next_key(wk_q, n_q);
		end else begin
			wk_q <= cur_key_q;
		end
		// Capture the key that holds the elapsed time
		if (found) begin
			span_q <= rd_data.span;
			v0_q   <= rd_data.v0;
			neg_q  <= diff_w[DATA_W];
			mag_q  <= diff_w[DATA_W] ? neg_diff[DATA_W-1:0] : diff_w[DATA_W-1:0];
		end
		if (state_q == S_MUL) begin
			prod_q <= mag_q * elapsed_q;
		end
		if (fin_go) begin
			out_q.sample_value <= neg_q ? (v0_q - div_quot) : (v0_q + div_quot);
			out_q.active_key   <= cur_key_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// A waiting result holds until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("result dropped or changed while waiting");

	// Remaining time must be below the chosen key's span before the blend
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (elapsed_q < span_q))
		else $error("elapsed time not below span");

	// Divider is shared and must never be restarted mid-operation
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider started while busy");
`endif

endmodule
